FILE: design/mf3_pkg.sv
// Shared types and constants for the 3x3 edge-aware median filter.
// Used by every module of the block; depends on nothing else.
package mf3_pkg;

   // Pixel and window geometry.
   localparam int PIX_W     = 8;
   localparam int NUM_TAPS  = 9;
   localparam int TAP_IDX_W = $clog2(NUM_TAPS);
   localparam int ROW_W     = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int MIN_SIZE     = 2;
   localparam int DEFAULT_MAX_WIDTH = 1024;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Sorted position picked for a full window, an edge and a corner.
   localparam logic [TAP_IDX_W-1:0] RANK_INTERIOR = 4'd4;
   localparam logic [TAP_IDX_W-1:0] RANK_EDGE     = 4'd2;
   localparam logic [TAP_IDX_W-1:0] RANK_CORNER   = 4'd1;

   // Value that stands in for a missing neighbor; it always sorts last.
   localparam logic [PIX_W-1:0] PAD_PIXEL = 8'hFF;

   typedef logic [NUM_TAPS-1:0][PIX_W-1:0] pix_vec_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             is_padding;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] filtered_pixel;
      logic             frame_last;
   } rsp_type;

   // Control that travels with an item through the sorting chain.
   typedef struct packed {
      logic [TAP_IDX_W-1:0] rank;
      logic                 last;
   } side_type;

   // Front stage: what an item needs once its line store data arrives.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             has_result;
      logic             row_start;
      logic             top_ex;
      logic             bot_ex;
      logic             left_ex;
      logic             last;
   } front_type;

endpackage

FILE: design/mf3_line_store.sv
// Line store holding the two previous rows per column, top row in the upper byte.
// One write port and one registered read port; uses mf3_pkg.
module mf3_line_store #(
   parameter int DEPTH = mf3_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [2*mf3_pkg::PIX_W-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [2*mf3_pkg::PIX_W-1:0]  wr_data
);
   import mf3_pkg::*;

   logic [2*PIX_W-1:0] mem_ff [DEPTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mf3_sort_stage.sv
// One stage of the odd-even transposition sorter: a row of compare-exchange cells.
// Registered output with valid and ready; uses mf3_pkg.
module mf3_sort_stage #(
   parameter int PHASE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  mf3_pkg::pix_vec_type  up_vals,
   input  mf3_pkg::side_type     up_side,
   output logic                  up_ready,
   output logic                  dn_valid,
   output mf3_pkg::pix_vec_type  dn_vals,
   output mf3_pkg::side_type     dn_side,
   input  logic                  dn_ready
);
   import mf3_pkg::*;

   logic        valid_ff;
   pix_vec_type vals_ff;
   pix_vec_type vals_in;
   side_type    side_ff;

   // Compare-exchange neighboring pairs that start at this stage's phase.
   always_comb begin
      vals_in = up_vals;
      for (int i = PHASE; i + 1 < NUM_TAPS; i += 2) begin
         if (up_vals[i] > up_vals[i+1]) begin
            vals_in[i]   = up_vals[i+1];
            vals_in[i+1] = up_vals[i];
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         vals_ff <= vals_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vals  = vals_ff;
   assign dn_side  = side_ff;

endmodule

FILE: design/median_filter_3x3_edge_aware_top.sv
// Top level of the 3x3 edge-aware median filter.
// Uses mf3_pkg, mf3_line_store and mf3_sort_stage.
//
// The block takes one pixel item per clock and gives one result per pixel in raster
// order, sustained at one item per cycle unless rsp_stall holds the output; the line
// store is read once and written once per item, and the sorter is a chain of nine
// registered compare-exchange stages that takes a new window every cycle unless
// stalled. A result passes through the front stage, the nine sorting stages and
// the output register after the item that completes its window is accepted, and
// results trail the input by image_width+1 items, so after the last pixel of a frame
// the host sends image_width+1 padding items; the final one carries frame_last.
// Interior pixels get the median of their 3x3 window, edge pixels the third smallest
// of six and corners the second smallest of four. The line store needs no clearing
// pass after reset. A register write restarts the frame.
module median_filter_3x3_edge_aware_top #(
   parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mf3_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mf3_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mf3_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);

   // Configuration and raster position.
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [PEND_W-1:0]       pend_ff, pend_in;
   logic [WID_W-1:0]        eff_w;
   logic [ROW_W-1:0]        eff_h;

   // Front stage and window.
   logic                      s1_valid_ff;
   front_type                 s1_ff, s1_in;
   logic [COL_W-1:0]          s1_col_ff;
   logic                      s1_ready, s1_adv;
   logic [2:0][2:0][PIX_W-1:0] win_ff, win_in;
   logic [2*PIX_W-1:0]        ls_rd_data;
   logic [2:0][PIX_W-1:0]     new_col;

   // Sorting chain.
   logic        stg_valid [NUM_TAPS+1];
   pix_vec_type stg_vals  [NUM_TAPS+1];
   side_type    stg_side  [NUM_TAPS+1];
   logic        stg_ready [NUM_TAPS+1];

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    out_ready;

   logic accept, take, flushing, wrap;
   logic is_rs, is_nm;
   logic [ROW_W-1:0]  centre_row;
   logic [WID_W-1:0]  col_ext;

   // Configuration writes; any write restarts the frame.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame size clamped into its legal range.
   always_comb begin
      if (32'(width_ff) < MIN_SIZE) begin
         eff_w = WID_W'(MIN_SIZE);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
      if (32'(height_ff) < MIN_SIZE) begin
         eff_h = ROW_W'(MIN_SIZE);
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         eff_h = ROW_W'(HEIGHT_LIMIT);
      end else begin
         eff_h = ROW_W'(height_ff);
      end
   end

   // Input handshake; padding outside a flush is taken and dropped.
   assign req_stall = !s1_ready;
   assign accept    = req_valid && !req_stall;
   assign flushing  = (pend_ff != '0);
   assign take      = accept && (flushing || !req_data.is_padding);

   // Position update and the flags of the result this item produces.
   always_comb begin
      col_ext = WID_W'(col_ff);
      wrap    = (col_ext + WID_W'(1)) == eff_w;
      col_in  = wrap ? '0 : col_ff + COL_W'(1);
      row_in  = wrap ? row_ff + ROW_W'(1) : row_ff;
      pend_in = pend_ff;
      if (flushing) begin
         pend_in = pend_ff - PEND_W'(1);
         if (pend_ff == PEND_W'(1)) begin
            col_in = '0;
            row_in = '0;
         end
      end else if (wrap && row_in == eff_h) begin
         pend_in = PEND_W'(eff_w) + PEND_W'(1);
      end

      is_rs      = (col_ff == '0) && (row_ff >= ROW_W'(2));
      is_nm      = (col_ff != '0) && (row_ff != '0);
      centre_row = is_rs ? row_ff - ROW_W'(2) : row_ff - ROW_W'(1);

      s1_in.pixel      = flushing ? '0 : req_data.pixel_value;
      s1_in.has_result = is_rs || is_nm;
      s1_in.row_start  = is_rs;
      s1_in.top_ex     = (centre_row == '0);
      s1_in.bot_ex     = (centre_row == eff_h - ROW_W'(1));
      s1_in.left_ex    = !is_rs && (col_ff == COL_W'(1));
      s1_in.last       = flushing && (pend_ff == PEND_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else if (take) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // Front stage waits for the line store read.
   assign s1_adv   = s1_valid_ff && stg_ready[0];
   assign s1_ready = !s1_valid_ff || stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ff     <= s1_in;
         s1_col_ff <= col_ff;
      end
   end

   mf3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (ls_rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({ls_rd_data[PIX_W-1:0], s1_ff.pixel})
   );

   // New window column: top row, middle row, incoming pixel.
   assign new_col[0] = ls_rd_data[2*PIX_W-1:PIX_W];
   assign new_col[1] = ls_rd_data[PIX_W-1:0];
   assign new_col[2] = s1_ff.pixel;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
         win_in[r][2] = new_col[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // Neighborhood for the sorter. Both cases take the old window's last two
   // columns as left and centre; a row start has no right neighbor.
   always_comb begin
      logic edge_rows, edge_cols;
      for (int r = 0; r < 3; r++) begin
         stg_vals[0][r*3]     = win_ff[r][1];
         stg_vals[0][r*3 + 1] = win_ff[r][2];
         stg_vals[0][r*3 + 2] = s1_ff.row_start ? PAD_PIXEL : new_col[r];
      end
      for (int k = 0; k < 3; k++) begin
         if (s1_ff.top_ex) begin
            stg_vals[0][k] = PAD_PIXEL;
         end
         if (s1_ff.bot_ex) begin
            stg_vals[0][6 + k] = PAD_PIXEL;
         end
         if (s1_ff.left_ex) begin
            stg_vals[0][k*3] = PAD_PIXEL;
         end
      end
      edge_rows = s1_ff.top_ex || s1_ff.bot_ex;
      edge_cols = s1_ff.left_ex || s1_ff.row_start;
      if (edge_rows && edge_cols) begin
         stg_side[0].rank = RANK_CORNER;
      end else if (edge_rows || edge_cols) begin
         stg_side[0].rank = RANK_EDGE;
      end else begin
         stg_side[0].rank = RANK_INTERIOR;
      end
      stg_side[0].last = s1_ff.last;
   end

   assign stg_valid[0] = s1_valid_ff && s1_ff.has_result;

   // Chain of sorting stages.
   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_sort
      mf3_sort_stage #(
         .PHASE (k % 2)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[k]),
         .up_vals  (stg_vals[k]),
         .up_side  (stg_side[k]),
         .up_ready (stg_ready[k]),
         .dn_valid (stg_valid[k+1]),
         .dn_vals  (stg_vals[k+1]),
         .dn_side  (stg_side[k+1]),
         .dn_ready (stg_ready[k+1])
      );
   end

   // Output register picks the ranked value.
   assign out_ready            = !rsp_valid_ff || !rsp_stall;
   assign stg_ready[NUM_TAPS]  = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stg_valid[NUM_TAPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_valid[NUM_TAPS]) begin
         rsp_data_ff.filtered_pixel <= stg_vals[NUM_TAPS][stg_side[NUM_TAPS].rank];
         rsp_data_ff.frame_last     <= stg_side[NUM_TAPS].last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
